@@ rtl/fpc_pkg.sv @@
// Film perforation counter: shared widths, register indexes and constants.
// Controller/datapath command and status structs.
// No dependencies.
package fpc_pkg;

	// payload widths
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned XOFF_W  = 12;
	localparam int unsigned BW_W    = 7;
	localparam int unsigned WR_W    = 7;
	localparam int unsigned CFG_AW  = 2;
	localparam int unsigned CFG_DW  = 12;
	localparam int unsigned SUM_W   = 14;
	localparam int unsigned TOT_W   = 20;
	localparam int unsigned CNT_W   = 24;
	localparam int unsigned COL_W   = 13;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] REG_BAND_X_OFFSET = 2'd0;
	localparam logic [CFG_AW-1:0] REG_BAND_WIDTH    = 2'd1;
	localparam logic [CFG_AW-1:0] REG_WINDOW_ROWS   = 2'd2;

	// register reset values
	localparam logic [XOFF_W-1:0] RST_BAND_X_OFFSET = 12'd0;
	localparam logic [BW_W-1:0]   RST_BAND_WIDTH    = 7'd8;
	localparam logic [WR_W-1:0]   RST_WINDOW_ROWS   = 7'd16;
	localparam logic [TOT_W-1:0]  RST_SEEN_MIN      = 20'd32640;

	// limits
	localparam logic [BW_W-1:0]  BAND_W_LIMIT  = 7'd64;
	localparam logic [WR_W-1:0]  WIN_LIMIT     = 7'd64;
	localparam logic [COL_W-1:0] LINE_LIMIT    = 13'd4096;
	localparam logic [CNT_W-1:0] COUNT_MAX     = 24'hFFFFFF;

	// window ring store
	localparam int unsigned RING_DEPTH = 64;
	localparam int unsigned RING_AW    = 6;

	// divide by ten: floor(d * RECIP_TEN / 2^RECIP_SHIFT), exact for d < 2^22
	localparam logic [TOT_W-1:0] RECIP_TEN   = 20'd838861;
	localparam int unsigned      RECIP_SHIFT = 23;
	localparam int unsigned      PROD_W      = 2 * TOT_W;

	// controller to datapath
	typedef struct packed {
		logic pix_take;    // pixel word accepted
		logic row_fin;     // accepted word ends a row
		logic store_row;   // write row sum to first-block store
		logic learn_init;  // clear window, seed max/min, rewind index
		logic fetch;       // read ring at position, store at index
		logic track;       // max/min tracking on the current total
		logic add_live;    // push live row sum into window
		logic add_stored;  // push stored row into window, step index
		logic hole_update; // threshold compare and count
		logic div_start;   // register scaled difference
		logic thr_load;    // set threshold, clear window, rewind index
		logic out_load;    // capture result word
	} fpc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic calibrated;
		logic idx_done;
	} fpc_sts_t;

endpackage

@@ rtl/fpc_in_if.sv @@
// Pixel input channel: valid/ready with pixel and row/block markers.
// Depends on fpc_pkg.
interface fpc_in_if import fpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             row_end;
	logic             block_end;

	modport source(output valid, output pixel, output row_end, output block_end, input ready);
	modport sink(input valid, input pixel, input row_end, input block_end, output ready);
endinterface

@@ rtl/fpc_out_if.sv @@
// Result channel: valid/ready with perforation total and learned threshold.
// Depends on fpc_pkg.
interface fpc_out_if import fpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] perforation_total;
	logic [TOT_W-1:0] threshold_level;

	modport source(output valid, output perforation_total, output threshold_level, input ready);
	modport sink(input valid, input perforation_total, input threshold_level, output ready);
endinterface

@@ rtl/fpc_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
// Depends on fpc_pkg.
interface fpc_cfg_if import fpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/fpc_ctrl.sv @@
// Perforation counter controller: sequences row store, learning, replay,
// live counting and result hand-off. Depends on fpc_pkg.
module fpc_ctrl import fpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_row_end,
	input  logic     in_block_end,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  fpc_sts_t sts,
	output fpc_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STORE,
		ST_LIVE_FETCH,
		ST_LIVE_ADD,
		ST_LIVE_CMP,
		ST_LEARN_INIT,
		ST_LEARN_NEXT,
		ST_LEARN_ADD,
		ST_DIV,
		ST_THR,
		ST_REPLAY_NEXT,
		ST_REPLAY_ADD,
		ST_REPLAY_CMP,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   blk_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.pix_take = accept;
				cmd.row_fin  = accept && (in_row_end || in_block_end);
			end
			ST_STORE:       cmd.store_row = 1'b1;
			ST_LIVE_FETCH:  cmd.fetch = 1'b1;
			ST_LIVE_ADD:    cmd.add_live = 1'b1;
			ST_LIVE_CMP:    cmd.hole_update = 1'b1;
			ST_LEARN_INIT:  cmd.learn_init = 1'b1;
			ST_LEARN_NEXT: begin
				cmd.fetch = !sts.idx_done;
				cmd.track = !sts.idx_done;
			end
			ST_LEARN_ADD:   cmd.add_stored = 1'b1;
			ST_DIV:         cmd.div_start = 1'b1;
			ST_THR:         cmd.thr_load = 1'b1;
			ST_REPLAY_NEXT: cmd.fetch = !sts.idx_done;
			ST_REPLAY_ADD:  cmd.add_stored = 1'b1;
			ST_REPLAY_CMP:  cmd.hole_update = 1'b1;
			ST_EMIT:        cmd.out_load = out_free;
			default:        cmd = '0;
		endcase
	end

	// state, block flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			blk_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_row_end || in_block_end)) begin
						blk_q   <= in_block_end;
						state_q <= sts.calibrated ? ST_LIVE_FETCH : ST_STORE;
					end
				end
				ST_STORE:      state_q <= blk_q ? ST_LEARN_INIT : ST_IDLE;
				ST_LIVE_FETCH: state_q <= ST_LIVE_ADD;
				ST_LIVE_ADD:   state_q <= ST_LIVE_CMP;
				ST_LIVE_CMP:   state_q <= blk_q ? ST_EMIT : ST_IDLE;
				ST_LEARN_INIT: state_q <= ST_LEARN_NEXT;
				ST_LEARN_NEXT: state_q <= sts.idx_done ? ST_DIV : ST_LEARN_ADD;
				ST_LEARN_ADD:  state_q <= ST_LEARN_NEXT;
				ST_DIV:        state_q <= ST_THR;
				ST_THR:        state_q <= ST_REPLAY_NEXT;
				ST_REPLAY_NEXT: state_q <= sts.idx_done ? ST_EMIT : ST_REPLAY_ADD;
				ST_REPLAY_ADD: state_q <= ST_REPLAY_CMP;
				ST_REPLAY_CMP: state_q <= ST_REPLAY_NEXT;
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/fpc_datapath.sv @@
// Perforation counter datapath: config registers, band accumulator, window
// ring, first-block row store, max/min tracking, threshold and count.
// Depends on fpc_pkg.
module fpc_datapath import fpc_pkg::*; #(
	parameter int unsigned MAX_BLOCK_ROWS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fpc_cmd_t          cmd,
	output fpc_sts_t          sts,
	input  logic [PIX_W-1:0]  pixel,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output logic [CNT_W-1:0]  perforation_total,
	output logic [TOT_W-1:0]  threshold_level
);

	localparam int unsigned BLK_AW = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1;
	localparam int unsigned BLK_CW = $clog2(MAX_BLOCK_ROWS + 1);
	localparam logic [BLK_CW-1:0] BLK_LIMIT = BLK_CW'(MAX_BLOCK_ROWS);

	// configuration
	logic [XOFF_W-1:0] x_off_q;
	logic [BW_W-1:0]   band_w_q;
	logic [WR_W-1:0]   win_rows_q;
	logic [BW_W-1:0]   eff_w;
	logic [WR_W-1:0]   eff_h;
	logic              win_cfg_clear;

	// band accumulation
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] col_off;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] acc_next;
	logic [SUM_W-1:0] row_sum_q;
	logic             in_band;

	// window
	logic [SUM_W-1:0]      ring_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] ring_vld_q;
	logic [RING_AW-1:0]    pos_q;
	logic [TOT_W-1:0]      total_q;
	logic [TOT_W-1:0]      total_next;
	logic [SUM_W-1:0]      ring_rd_s1;
	logic                  ring_vld_s1;
	logic [SUM_W-1:0]      ring_old;
	logic [SUM_W-1:0]      add_val;
	logic                  win_clear;
	logic                  win_add;
	logic                  pos_wrap;

	// first-block store
	logic [SUM_W-1:0]  blk_mem [MAX_BLOCK_ROWS];
	logic [SUM_W-1:0]  blk_rd_s1;
	logic [BLK_CW-1:0] stored_q;
	logic [BLK_CW-1:0] idx_q;
	logic              store_room;

	// learning
	logic [TOT_W-1:0]    max_q;
	logic [TOT_W-1:0]    min_q;
	logic [2*WR_W-1:0]   wh;
	logic [TOT_W+1:0]    min_seed;
	logic                min_above;
	logic [TOT_W-1:0]    diff;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-1:0]   prod_s1;
	logic                neg_s1;
	logic [TOT_W-1:0]    quot;

	// counting and result
	logic [TOT_W-1:0] thr_q;
	logic             calibrated_q;
	logic             was_dark_q;
	logic [CNT_W-1:0] hole_q;
	logic [CNT_W-1:0] out_total_q;
	logic [TOT_W-1:0] out_thr_q;

	// clamped register values
	assign eff_w = (band_w_q > BAND_W_LIMIT) ? BAND_W_LIMIT : band_w_q;
	assign eff_h = (win_rows_q == '0) ? WR_W'(1) :
	               ((win_rows_q > WIN_LIMIT) ? WIN_LIMIT : win_rows_q);

	assign win_cfg_clear = cfg_we && (cfg_index == REG_WINDOW_ROWS);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q    <= RST_BAND_X_OFFSET;
			band_w_q   <= RST_BAND_WIDTH;
			win_rows_q <= RST_WINDOW_ROWS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAND_X_OFFSET: x_off_q    <= cfg_data[XOFF_W-1:0];
				REG_BAND_WIDTH:    band_w_q   <= cfg_data[BW_W-1:0];
				REG_WINDOW_ROWS:   win_rows_q <= cfg_data[WR_W-1:0];
				default:           x_off_q    <= x_off_q;
			endcase
		end
	end

	// band membership of the current column
	assign col_off  = col_q - COL_W'(x_off_q);
	assign in_band  = (col_q < LINE_LIMIT) && (col_q >= COL_W'(x_off_q)) &&
	                  (col_off < COL_W'(eff_w));
	assign acc_next = acc_q + (in_band ? SUM_W'(pixel) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			acc_q <= '0;
		end else if (cmd.pix_take) begin
			if (cmd.row_fin) begin
				col_q <= '0;
				acc_q <= '0;
			end else begin
				acc_q <= acc_next;
				if (col_q < LINE_LIMIT) col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_fin) row_sum_q <= acc_next;
	end

	// window ring update
	assign win_clear  = win_cfg_clear || cmd.learn_init || cmd.thr_load;
	assign win_add    = cmd.add_live || cmd.add_stored;
	assign ring_old   = ring_vld_s1 ? ring_rd_s1 : '0;
	assign add_val    = cmd.add_stored ? blk_rd_s1 : row_sum_q;
	assign total_next = total_q - TOT_W'(ring_old) + TOT_W'(add_val);
	assign pos_wrap   = (WR_W'(pos_q) + WR_W'(1)) == eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			pos_q      <= '0;
			total_q    <= '0;
		end else if (win_clear) begin
			ring_vld_q <= '0;
			pos_q      <= '0;
			total_q    <= '0;
		end else if (win_add) begin
			ring_vld_q[pos_q] <= 1'b1;
			pos_q             <= pos_wrap ? '0 : pos_q + RING_AW'(1);
			total_q           <= total_next;
		end
	end

	always_ff @(posedge clk) begin
		if (win_add) ring_mem[pos_q] <= add_val;
		if (cmd.fetch) begin
			ring_rd_s1  <= ring_mem[pos_q];
			ring_vld_s1 <= ring_vld_q[pos_q];
		end
	end

	// first-block row store
	assign store_room = stored_q < BLK_LIMIT;

	always_ff @(posedge clk) begin
		if (cmd.store_row && store_room) blk_mem[stored_q[BLK_AW-1:0]] <= row_sum_q;
		if (cmd.fetch) blk_rd_s1 <= blk_mem[idx_q[BLK_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.store_row && store_room) stored_q <= stored_q + BLK_CW'(1);
			if (cmd.learn_init || cmd.thr_load) idx_q <= '0;
			else if (cmd.add_stored) idx_q <= idx_q + BLK_CW'(1);
		end
	end

	// max/min tracking and threshold
	assign wh        = (2*WR_W)'(eff_w) * (2*WR_W)'(eff_h);
	assign min_seed  = {wh, 8'd0} - (TOT_W+2)'(wh);
	assign min_above = min_q > max_q;
	assign diff      = min_above ? (min_q - max_q) : (max_q - min_q);
	assign prod      = PROD_W'(diff) * PROD_W'(RECIP_TEN);
	assign quot      = TOT_W'(prod_s1 >> RECIP_SHIFT);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			prod_s1 <= prod;
			neg_s1  <= min_above;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q        <= '0;
			min_q        <= RST_SEEN_MIN;
			thr_q        <= '0;
			calibrated_q <= 1'b0;
		end else begin
			if (cmd.learn_init) begin
				max_q <= '0;
				min_q <= min_seed[TOT_W-1:0];
			end else if (cmd.track && (32'(idx_q) >= 32'(eff_h))) begin
				if (total_q > max_q) max_q <= total_q;
				else if (total_q < min_q) min_q <= total_q;
			end
			if (cmd.thr_load) begin
				thr_q        <= neg_s1 ? (max_q + quot) : (max_q - quot);
				calibrated_q <= 1'b1;
			end
		end
	end

	// opaque-to-transparent counting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_dark_q <= 1'b1;
			hole_q     <= '0;
		end else if (cmd.hole_update) begin
			if (total_q >= thr_q) begin
				if (was_dark_q && (hole_q != COUNT_MAX)) hole_q <= hole_q + CNT_W'(1);
				was_dark_q <= 1'b0;
			end else begin
				was_dark_q <= 1'b1;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_total_q <= hole_q;
			out_thr_q   <= thr_q;
		end
	end

	assign perforation_total = out_total_q;
	assign threshold_level   = out_thr_q;
	assign sts.calibrated    = calibrated_q;
	assign sts.idx_done      = idx_q >= stored_q;

endmodule

@@ rtl/film_perforation_counter_unit.sv @@
// Film perforation counter, top level. One pixel word per cycle within a row; a row end
// adds a row store write before calibration and a ring read, add and compare after.
// The first block end then learns over the stored rows (fetch, add per row), divides, sets the
// threshold and replays the rows (fetch, add, compare each). Other block ends: read, add, compare.
// The result word sits in an output register; pixels are taken while it waits.
// Async reset clears control, window valid bits and counters; the row store is not cleared.
module film_perforation_counter_unit import fpc_pkg::*; #(
	parameter int unsigned MAX_BLOCK_ROWS = 1024
) (
	input logic   clk,
	input logic   arst_n,
	fpc_in_if.sink    pixels,
	fpc_out_if.source results,
	fpc_cfg_if.sink   cfg
);

	fpc_cmd_t cmd;
	fpc_sts_t sts;
	logic     cfg_we;

	// configuration is always taken
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	fpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pixels.valid),
		.in_row_end   (pixels.row_end),
		.in_block_end (pixels.block_end),
		.in_ready     (pixels.ready),
		.out_valid    (results.valid),
		.out_ready    (results.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	fpc_datapath #(
		.MAX_BLOCK_ROWS (MAX_BLOCK_ROWS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.pixel             (pixels.pixel),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.perforation_total (results.perforation_total),
		.threshold_level   (results.threshold_level)
	);

endmodule
